// ===== rtl/core/ggl_pkg.sv =====
// Shared types and constants for the grid gradient / Laplacian block.
package ggl_pkg;

  localparam int MAX_DIM_DEF     = 256;
  localparam int HEIGHT_BITS_DEF = 16;

  localparam int CFG_W     = 9;
  localparam int COORD_W   = 8;
  localparam int GRAD_W    = 17;
  localparam int LAP_W     = 19;
  localparam int NCOORD_W  = 10;
  localparam int GRAD_LIMIT = 65535;
  localparam int LAP_LIMIT  = 262140;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef logic [2:0] slot_t;
  localparam slot_t SLOT_CENTER = 3'd0;
  localparam slot_t SLOT_XA     = 3'd1;
  localparam slot_t SLOT_XB     = 3'd2;
  localparam slot_t SLOT_YA     = 3'd3;
  localparam slot_t SLOT_YB     = 3'd4;
  localparam int    NUM_SLOTS   = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    EDGE_FIRST,
    EDGE_LAST,
    EDGE_MID
  } edge_mode_t;

  typedef struct packed {
    logic  mem_write;
    logic  query_load;
    logic  rd_en;
    slot_t rd_slot;
    logic  cap_en;
    slot_t cap_slot;
    logic  calc_en;
    logic  out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_outside;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ===== rtl/core/grid_gradient_laplacian_core.sv =====
// Top level of the grid gradient / Laplacian block.
// Holds a MAX_DIM x MAX_DIM grid of signed heights in one single-port memory.
// A write item stores a height and gives no result. A query
// item reads the cell and four neighbors through that one port, one read per
// cycle, then forms the differences and saturates. An inside query goes
// through the read states, a last capture state and a compute state to the
// done state; an outside query goes straight to done. The next item is taken
// once the result is registered; while an earlier result still waits in the
// output register, the query holds in done.
// Neighbors outside the configured grid read as zero; grid_width and
// grid_height above MAX_DIM act as MAX_DIM. The grid is not cleared at reset.
module grid_gradient_laplacian_core #(
  parameter int MAX_DIM     = ggl_pkg::MAX_DIM_DEF,
  parameter int HEIGHT_BITS = ggl_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ggl_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [ggl_pkg::COORD_W-1:0]         col,
  input  logic [ggl_pkg::COORD_W-1:0]         row,
  input  logic signed [HEIGHT_BITS-1:0]       height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ggl_pkg::GRAD_W-1:0]   grad_x_halves,
  output logic signed [ggl_pkg::GRAD_W-1:0]   grad_y_halves,
  output logic signed [ggl_pkg::LAP_W-1:0]    laplacian,
  output logic                                outside
);

  ggl_pkg::ctrl_cmd_t  cmd;
  ggl_pkg::ctrl_stat_t stat;

  ggl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  ggl_datapath #(
    .MAX_DIM     (MAX_DIM),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .col           (col),
    .row           (row),
    .height        (height),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .grad_x_halves (grad_x_halves),
    .grad_y_halves (grad_y_halves),
    .laplacian     (laplacian),
    .outside       (outside)
  );

endmodule

// ===== rtl/core/ggl_ctrl.sv =====
// Sequencer for writes and queries: read slots, compute, result hand-off.
module ggl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  ggl_pkg::ctrl_stat_t   stat,
  output ggl_pkg::ctrl_cmd_t    cmd
);

  ggl_pkg::state_t state, state_next;
  ggl_pkg::slot_t  slot, slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ggl_pkg::ST_IDLE;
      slot  <= ggl_pkg::SLOT_CENTER;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  always_comb begin
    state_next = state;
    slot_next  = slot;
    unique case (state)
      ggl_pkg::ST_IDLE: begin
        slot_next = ggl_pkg::SLOT_CENTER;
        if (in_valid && command == ggl_pkg::CMD_QUERY) begin
          state_next = stat.in_outside ? ggl_pkg::ST_DONE : ggl_pkg::ST_READ;
        end
      end
      ggl_pkg::ST_READ: begin
        slot_next = slot + 3'd1;
        if (slot == ggl_pkg::SLOT_YB) begin
          state_next = ggl_pkg::ST_LAST;
        end
      end
      ggl_pkg::ST_LAST: state_next = ggl_pkg::ST_CALC;
      ggl_pkg::ST_CALC: state_next = ggl_pkg::ST_DONE;
      ggl_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_next = ggl_pkg::ST_IDLE;
        end
      end
      default: state_next = ggl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      ggl_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.mem_write  = in_valid && command == ggl_pkg::CMD_WRITE;
        cmd.query_load = in_valid && command == ggl_pkg::CMD_QUERY;
      end
      ggl_pkg::ST_READ: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_slot  = slot;
        cmd.cap_en   = slot != ggl_pkg::SLOT_CENTER;
        cmd.cap_slot = slot - 3'd1;
      end
      ggl_pkg::ST_LAST: begin
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = ggl_pkg::SLOT_YB;
      end
      ggl_pkg::ST_CALC: cmd.calc_en = 1'b1;
      ggl_pkg::ST_DONE: cmd.out_load = stat.out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/ggl_datapath.sv =====
// Grid memory, neighbor addressing, difference arithmetic and result register.
module ggl_datapath #(
  parameter int MAX_DIM     = ggl_pkg::MAX_DIM_DEF,
  parameter int HEIGHT_BITS = ggl_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ggl_pkg::CFG_W-1:0]           cfg_data,
  input  logic [ggl_pkg::COORD_W-1:0]         col,
  input  logic [ggl_pkg::COORD_W-1:0]         row,
  input  logic signed [HEIGHT_BITS-1:0]       height,
  input  ggl_pkg::ctrl_cmd_t                  cmd,
  output ggl_pkg::ctrl_stat_t                 stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ggl_pkg::GRAD_W-1:0]   grad_x_halves,
  output logic signed [ggl_pkg::GRAD_W-1:0]   grad_y_halves,
  output logic signed [ggl_pkg::LAP_W-1:0]    laplacian,
  output logic                                outside
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + ggl_pkg::NCOORD_W;
  localparam int HB    = HEIGHT_BITS;
  localparam int GW    = HB + 1;
  localparam int LW    = HB + 2;
  localparam int SW    = HB + 3;
  localparam int CMPW  = (SW > ggl_pkg::LAP_W + 1) ? SW : ggl_pkg::LAP_W + 1;
  localparam int NW    = ggl_pkg::NCOORD_W;
  localparam logic signed [CMPW-1:0] GLIM = CMPW'(ggl_pkg::GRAD_LIMIT);
  localparam logic signed [CMPW-1:0] LLIM = CMPW'(ggl_pkg::LAP_LIMIT);

  logic [ggl_pkg::CFG_W-1:0] grid_width, grid_height;
  logic [ggl_pkg::CFG_W-1:0] w_eff, h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= ggl_pkg::CFG_W'(256);
      grid_height <= ggl_pkg::CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ggl_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        ggl_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (32'(grid_width) > 32'(MAX_DIM)) ? ggl_pkg::CFG_W'(MAX_DIM) : grid_width;
  assign h_eff = (32'(grid_height) > 32'(MAX_DIM)) ? ggl_pkg::CFG_W'(MAX_DIM) : grid_height;

  assign stat.in_outside = ({1'b0, col} >= w_eff) || ({1'b0, row} >= h_eff);

  // query registers
  logic [ggl_pkg::COORD_W-1:0] col_q, row_q;
  ggl_pkg::edge_mode_t         mode_x, mode_y;
  logic                        outside_q;

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      col_q     <= col;
      row_q     <= row;
      outside_q <= stat.in_outside;
      if (col == '0) begin
        mode_x <= ggl_pkg::EDGE_FIRST;
      end else if ({1'b0, col} == w_eff - ggl_pkg::CFG_W'(1)) begin
        mode_x <= ggl_pkg::EDGE_LAST;
      end else begin
        mode_x <= ggl_pkg::EDGE_MID;
      end
      if (row == '0) begin
        mode_y <= ggl_pkg::EDGE_FIRST;
      end else if ({1'b0, row} == h_eff - ggl_pkg::CFG_W'(1)) begin
        mode_y <= ggl_pkg::EDGE_LAST;
      end else begin
        mode_y <= ggl_pkg::EDGE_MID;
      end
    end
  end

  function automatic logic signed [2:0] off_a(ggl_pkg::edge_mode_t m);
    case (m)
      ggl_pkg::EDGE_LAST: off_a = -3'sd1;
      default:            off_a = 3'sd1;
    endcase
  endfunction

  function automatic logic signed [2:0] off_b(ggl_pkg::edge_mode_t m);
    case (m)
      ggl_pkg::EDGE_FIRST: off_b = 3'sd2;
      ggl_pkg::EDGE_LAST:  off_b = -3'sd2;
      default:             off_b = -3'sd1;
    endcase
  endfunction

  // neighbor coordinate for the slot being read
  logic signed [2:0]    dx, dy;
  logic signed [NW-1:0] nc, nr;
  logic                 n_ok;
  logic [PW-1:0]        rd_prod, wr_prod;
  logic [AW-1:0]        mem_addr;
  logic                 wr_in_range;

  always_comb begin
    dx = 3'sd0;
    dy = 3'sd0;
    case (cmd.rd_slot)
      ggl_pkg::SLOT_XA: dx = off_a(mode_x);
      ggl_pkg::SLOT_XB: dx = off_b(mode_x);
      ggl_pkg::SLOT_YA: dy = off_a(mode_y);
      ggl_pkg::SLOT_YB: dy = off_b(mode_y);
      default: ;
    endcase
  end

  assign nc   = $signed({2'b00, col_q}) + NW'(dx);
  assign nr   = $signed({2'b00, row_q}) + NW'(dy);
  assign n_ok = !nc[NW-1] && !nr[NW-1] &&
                (nc[ggl_pkg::CFG_W-1:0] < w_eff) && (nr[ggl_pkg::CFG_W-1:0] < h_eff);

  assign rd_prod = PW'(nr[ggl_pkg::CFG_W-1:0]) * PW'(MAX_DIM) + PW'(nc[ggl_pkg::CFG_W-1:0]);
  assign wr_prod = PW'(row) * PW'(MAX_DIM) + PW'(col);
  assign wr_in_range = (32'(col) < 32'(MAX_DIM)) && (32'(row) < 32'(MAX_DIM));
  assign mem_addr = cmd.rd_en ? rd_prod[AW-1:0] : wr_prod[AW-1:0];

  logic signed [HB-1:0] mem [DEPTH];
  logic signed [HB-1:0] rdata;
  logic                 rd_ok;

  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_in_range) begin
      mem[mem_addr] <= height;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_ok <= n_ok;
    end
  end

  logic signed [HB-1:0] vals [ggl_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      vals[cmd.cap_slot] <= rd_ok ? rdata : '0;
    end
  end

  // differences
  logic signed [LW-1:0] c0, xa, xb, ya, yb;
  logic signed [GW-1:0] gx, gy;
  logic signed [LW-1:0] lx, ly;

  assign c0 = LW'(vals[ggl_pkg::SLOT_CENTER]);
  assign xa = LW'(vals[ggl_pkg::SLOT_XA]);
  assign xb = LW'(vals[ggl_pkg::SLOT_XB]);
  assign ya = LW'(vals[ggl_pkg::SLOT_YA]);
  assign yb = LW'(vals[ggl_pkg::SLOT_YB]);

  always_ff @(posedge clk) begin
    if (cmd.calc_en) begin
      case (mode_x)
        ggl_pkg::EDGE_FIRST: begin
          gx <= GW'(xa - c0);
          lx <= xb - (xa <<< 1) + c0;
        end
        ggl_pkg::EDGE_LAST: begin
          gx <= GW'(c0 - xa);
          lx <= c0 - (xa <<< 1) + xb;
        end
        default: begin
          gx <= GW'(xa - xb);
          lx <= xa - (c0 <<< 1) + xb;
        end
      endcase
      case (mode_y)
        ggl_pkg::EDGE_FIRST: begin
          gy <= GW'(ya - c0);
          ly <= yb - (ya <<< 1) + c0;
        end
        ggl_pkg::EDGE_LAST: begin
          gy <= GW'(c0 - ya);
          ly <= c0 - (ya <<< 1) + yb;
        end
        default: begin
          gy <= GW'(ya - yb);
          ly <= ya - (c0 <<< 1) + yb;
        end
      endcase
    end
  end

  // saturation and result register
  logic signed [CMPW-1:0] gx_w, gy_w, lap_w;
  logic signed [CMPW-1:0] gx_s, gy_s, lap_s;

  assign gx_w  = CMPW'(gx);
  assign gy_w  = CMPW'(gy);
  assign lap_w = CMPW'(SW'(lx) + SW'(ly));

  assign gx_s  = (gx_w > GLIM) ? GLIM : ((gx_w < -GLIM) ? -GLIM : gx_w);
  assign gy_s  = (gy_w > GLIM) ? GLIM : ((gy_w < -GLIM) ? -GLIM : gy_w);
  assign lap_s = (lap_w > LLIM) ? LLIM : ((lap_w < -LLIM) ? -LLIM : lap_w);

  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      outside <= outside_q;
      if (outside_q) begin
        grad_x_halves <= '0;
        grad_y_halves <= '0;
        laplacian     <= '0;
      end else begin
        grad_x_halves <= gx_s[ggl_pkg::GRAD_W-1:0];
        grad_y_halves <= gy_s[ggl_pkg::GRAD_W-1:0];
        laplacian     <= lap_s[ggl_pkg::LAP_W-1:0];
      end
    end
  end

endmodule
